### rtl/pf_pkg.sv
// Package for the Playfair digraph cipher: letter, pair and job types,
// key-square constants and the lookup functions used by the pair transform.
// No dependencies.
package pf_pkg;

    typedef logic [4:0]  t_letter;
    typedef logic [2:0]  t_pos;
    typedef logic [24:0] t_row;
    typedef t_row [4:0]  t_square;
    typedef logic [2:0]  t_cfg_idx;

    localparam int SQ_DIM = 5;

    localparam t_letter LETTER_X = 5'd23;
    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;

    // Register index of the last key-square row.
    localparam t_cfg_idx CFG_ROW_LAST = 3'd4;

    // Reset square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z.
    localparam t_square SQUARE_RST = {25'd27025109, 25'd21613104, 25'd16201099,
                                      25'd10755269, 25'd4294688};

    typedef struct packed {
        t_letter a;
        t_letter b;
        logic    dec;
        logic    last;
    } t_pair;

    typedef struct packed {
        logic  valid;
        logic  two;
        t_pair p0;
        t_pair p1;
    } t_job;

    typedef struct packed {
        t_letter letter;
        logic    last;
    } t_out;

    typedef struct packed {
        t_pos row;
        t_pos col;
    } t_loc;

    // Move one place along a row or column, wrapping at the edge.
    function automatic t_pos step_pos(t_pos p, logic dec);
        t_pos q;
        if (dec) begin
            q = (p == 3'd0) ? 3'd4 : p - 3'd1;
        end else begin
            q = (p == 3'd4) ? 3'd0 : p + 3'd1;
        end
        return q;
    endfunction

    function automatic t_letter cell_at(t_square sq, t_pos r, t_pos c);
        t_row    row;
        t_letter l;
        row = sq[r];
        case (c)
            3'd0:    l = row[4:0];
            3'd1:    l = row[9:5];
            3'd2:    l = row[14:10];
            3'd3:    l = row[19:15];
            3'd4:    l = row[24:20];
            default: l = row[4:0];
        endcase
        return l;
    endfunction

    // First match in row-major order wins; a letter not found sits at 0,0.
    function automatic t_loc locate(t_square sq, t_letter letter);
        t_loc loc;
        loc = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (sq[r][5*c +: 5] == letter) begin
                    loc.row = t_pos'(r);
                    loc.col = t_pos'(c);
                end
            end
        end
        return loc;
    endfunction

endpackage

### rtl/pf_pair_former.sv
// Pair former: holds the pending letter and turns accepted items into
// pair jobs. Depends on pf_pkg.
module pf_pair_former
    import pf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    i_func,
    input  t_letter i_letter_in,
    input  logic    i_last_in,
    input  logic    i_take,
    output t_job    o_job
);

    t_letter r_pend_letter, n_pend_letter;
    logic    r_pend_valid, n_pend_valid;
    logic    r_pend_mode, n_pend_mode;
    t_job    r_job, n_job;
    t_letter w_letter;
    logic    w_accept;

    always_comb begin
        w_letter = (i_letter_in == LETTER_J) ? LETTER_I : i_letter_in;
        o_ready  = !r_job.valid || i_take;
        w_accept = i_valid && o_ready;

        n_pend_letter = r_pend_letter;
        n_pend_valid  = r_pend_valid;
        n_pend_mode   = r_pend_mode;
        n_job         = r_job;
        n_job.valid   = r_job.valid && !i_take;

        if (w_accept) begin
            n_job = '0;
            if (!r_pend_valid) begin
                if (i_last_in) begin
                    // A lone final letter is padded at once.
                    n_job.valid   = 1'b1;
                    n_job.p0      = '{a: w_letter, b: LETTER_X, dec: i_func, last: 1'b1};
                    n_pend_letter = '0;
                    n_pend_valid  = 1'b0;
                    n_pend_mode   = 1'b0;
                end else begin
                    n_pend_letter = w_letter;
                    n_pend_valid  = 1'b1;
                    n_pend_mode   = i_func;
                end
            end else if (!r_pend_mode && (r_pend_letter == w_letter)) begin
                // Doubled letter in encryption: split with x, keep the new one.
                n_job.valid = 1'b1;
                n_job.p0    = '{a: r_pend_letter, b: LETTER_X, dec: 1'b0, last: 1'b0};
                if (i_last_in) begin
                    n_job.two     = 1'b1;
                    n_job.p1      = '{a: w_letter, b: LETTER_X, dec: i_func, last: 1'b1};
                    n_pend_letter = '0;
                    n_pend_valid  = 1'b0;
                    n_pend_mode   = 1'b0;
                end else begin
                    n_pend_letter = w_letter;
                    n_pend_valid  = 1'b1;
                    n_pend_mode   = i_func;
                end
            end else begin
                n_job.valid   = 1'b1;
                n_job.p0      = '{a: r_pend_letter, b: w_letter, dec: r_pend_mode,
                                  last: i_last_in};
                n_pend_letter = '0;
                n_pend_valid  = 1'b0;
                n_pend_mode   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_letter <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_mode   <= 1'b0;
            r_job         <= '0;
        end else begin
            r_pend_letter <= n_pend_letter;
            r_pend_valid  <= n_pend_valid;
            r_pend_mode   <= n_pend_mode;
            r_job         <= n_job;
        end
    end

    assign o_job = r_job;

endmodule

### rtl/pf_pair_xform.sv
// Pair transform: locates both letters of a pair in the key square and
// applies the row, column or rectangle rule. Depends on pf_pkg.
module pf_pair_xform
    import pf_pkg::*;
(
    input  t_square i_square,
    input  t_pair   i_pair,
    output t_letter o_first,
    output t_letter o_second
);

    t_loc w_l1, w_l2;

    always_comb begin
        w_l1 = locate(i_square, i_pair.a);
        w_l2 = locate(i_square, i_pair.b);
        if (w_l1.row == w_l2.row) begin
            o_first  = cell_at(i_square, w_l1.row, step_pos(w_l1.col, i_pair.dec));
            o_second = cell_at(i_square, w_l1.row, step_pos(w_l2.col, i_pair.dec));
        end else if (w_l1.col == w_l2.col) begin
            o_first  = cell_at(i_square, step_pos(w_l1.row, i_pair.dec), w_l1.col);
            o_second = cell_at(i_square, step_pos(w_l2.row, i_pair.dec), w_l2.col);
        end else begin
            o_first  = cell_at(i_square, w_l1.row, w_l2.col);
            o_second = cell_at(i_square, w_l2.row, w_l1.col);
        end
    end

endmodule

### rtl/pf_out_fifo.sv
// Output letter queue: takes two or four letters at once, gives one per
// cycle while the receiver is ready. Depends on pf_pkg.
module pf_out_fifo
    import pf_pkg::*;
#(
    parameter int DEPTH = 8
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_four,
    input  t_out [3:0] i_data,
    output logic       o_push_ok,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_out            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   w_n;
    logic [CW-1:0]   w_wn;
    logic            w_pop;
    logic [PW-1:0]   w_widx [4];
    logic [PW:0]     w_sum  [4];
    logic [PW:0]     w_wsum;
    logic [PW:0]     w_rsum;

    always_comb begin
        w_n       = i_four ? CW'(4) : CW'(2);
        o_push_ok = i_push && (({1'b0, r_count} + {1'b0, w_n}) <= (CW + 1)'(DEPTH));
        w_wn      = o_push_ok ? w_n : '0;
        o_valid   = (r_count != '0);
        w_pop     = o_valid && i_ready;
        o_data    = r_mem[r_rptr];

        for (int k = 0; k < 4; k++) begin
            w_sum[k] = {1'b0, r_wptr} + (PW + 1)'(k);
            if (w_sum[k] >= (PW + 1)'(DEPTH)) begin
                w_sum[k] = w_sum[k] - (PW + 1)'(DEPTH);
            end
            w_widx[k] = w_sum[k][PW-1:0];
        end

        w_wsum = {1'b0, r_wptr} + (PW + 1)'(w_wn);
        if (w_wsum >= (PW + 1)'(DEPTH)) begin
            w_wsum = w_wsum - (PW + 1)'(DEPTH);
        end
        n_wptr = w_wsum[PW-1:0];

        w_rsum = {1'b0, r_rptr} + (PW + 1)'(w_pop);
        if (w_rsum >= (PW + 1)'(DEPTH)) begin
            w_rsum = w_rsum - (PW + 1)'(DEPTH);
        end
        n_rptr = w_rsum[PW-1:0];

        n_count = r_count + w_wn - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (o_push_ok && (CW'(k) < w_n)) begin
                r_mem[w_widx[k]] <= i_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

### rtl/playfair_digraph_cipher.sv
// Top level of the streaming Playfair digraph cipher: key-square registers,
// pair former, two pair transforms and the output queue. Depends on pf_pkg.
//
// The block takes one letter per item and can accept an item in every cycle
// that input ready is high. Letters are paired in the pair former, which
// keeps at most one pending letter; a completed pair (or a split doubled
// letter, or a padded final letter) becomes a job in a single job register.
// The two pair transforms look both letters of that job up in the key square
// by parallel compares, and the resulting two or four letters are written
// into the output queue together once it has room. Results leave the queue
// one per cycle while the receiver is ready, so a steady stream of pairs runs
// at one letter per cycle in and out. Input ready drops only while a job
// waits for room in the queue, which holds OUT_DEPTH letters (it must be at
// least four, which the block does not check, so that a four-letter job
// always fits once the queue drains). Key-square rows are written through
// the plain write port and take effect for the next job; write them while
// idle.
module playfair_digraph_cipher
    import pf_pkg::*;
#(
    parameter int OUT_DEPTH = 8
)(
    input  logic     i_clk,
    input  logic     i_rst_n,

    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_row     i_cfg_data,

    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_func,
    input  t_letter  i_letter_in,
    input  logic     i_last_in,

    output logic     o_valid,
    input  logic     i_ready,
    output t_letter  o_letter_out,
    output logic     o_last_out
);

    t_square    r_square;
    t_job       w_job;
    logic       w_take;
    t_letter    w_p0_first, w_p0_second;
    t_letter    w_p1_first, w_p1_second;
    t_out [3:0] w_push_data;
    t_out       w_head;

    // Key-square rows; indexes past the last row are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= SQUARE_RST;
        end else if (i_cfg_we && (i_cfg_idx <= CFG_ROW_LAST)) begin
            r_square[i_cfg_idx] <= i_cfg_data;
        end
    end

    pf_pair_former u_former (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_letter_in (i_letter_in),
        .i_last_in   (i_last_in),
        .i_take      (w_take),
        .o_job       (w_job)
    );

    pf_pair_xform u_xform0 (
        .i_square (r_square),
        .i_pair   (w_job.p0),
        .o_first  (w_p0_first),
        .o_second (w_p0_second)
    );

    pf_pair_xform u_xform1 (
        .i_square (r_square),
        .i_pair   (w_job.p1),
        .o_first  (w_p1_first),
        .o_second (w_p1_second)
    );

    // The last mark only ever rides on the second letter of a pair.
    always_comb begin
        w_push_data[0] = '{letter: w_p0_first,  last: 1'b0};
        w_push_data[1] = '{letter: w_p0_second, last: w_job.p0.last};
        w_push_data[2] = '{letter: w_p1_first,  last: 1'b0};
        w_push_data[3] = '{letter: w_p1_second, last: w_job.p1.last};
    end

    pf_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_job.valid),
        .i_four    (w_job.two),
        .i_data    (w_push_data),
        .o_push_ok (w_take),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (w_head)
    );

    assign o_letter_out = w_head.letter;
    assign o_last_out   = w_head.last;

    // A four-letter job is a split followed by the final pad, so only its
    // second pair may carry the last mark.
    a_last_on_final_pair : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job.valid && w_job.two) |-> (!w_job.p0.last && w_job.p1.last))
        else $error("last mark on the wrong pair of a four-letter job");

    // Input back-pressure comes only from a job that the queue cannot take.
    a_ready_only_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (w_job.valid && !w_take))
        else $error("input stalled without a waiting job");

    // The queue is empty straight after reset.
    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered directly after reset");

    // A job that could not move is still there, unchanged, in the next cycle.
    a_job_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job.valid && !w_take) |=> (w_job.valid && $stable(w_job)))
        else $error("stalled job lost or changed");

endmodule

### tb/sv/pf_sb_pkg.sv
// Scoreboard for the Playfair digraph cipher testbench: a letter-pairing
// predictor with its own key square and a queue of due output letters.
// Depends on pf_pkg for the letter, row, square and output types.
package pf_sb_pkg;
    import pf_pkg::*;

    class digraph_scoreboard;
        t_square key_sq;
        t_letter held_letter;
        bit      held_valid;
        bit      held_dec;
        t_out    due_letters[$];
        int      mismatches;
        int      letters_out;
        int      enc_pairs;
        int      dec_pairs;
        int      splits;

        function new();
            key_sq      = SQUARE_RST;
            held_letter = '0;
            held_valid  = 1'b0;
            held_dec    = 1'b0;
            mismatches  = 0;
            letters_out = 0;
            enc_pairs   = 0;
            dec_pairs   = 0;
            splits      = 0;
        endfunction

        function void set_row(int idx, t_row value);
            key_sq[idx] = value;
        endfunction

        function int outstanding();
            return due_letters.size();
        endfunction

        function t_letter square_cell(int r, int c);
            return key_sq[r][5*c +: 5];
        endfunction

        // Row-major search; the first hit wins and a miss lands on the corner.
        function void find_letter(input t_letter l, output int row, output int col);
            bit found;
            found = 1'b0;
            row   = 0;
            col   = 0;
            for (int r = 0; r < SQ_DIM; r++) begin
                for (int c = 0; c < SQ_DIM; c++) begin
                    if (!found && square_cell(r, c) == l) begin
                        found = 1'b1;
                        row   = r;
                        col   = c;
                    end
                end
            end
        endfunction

        function void queue_pair(t_letter first, t_letter second, bit dec, bit fin);
            int   r1, c1, r2, c2, step;
            t_out o1, o2;
            step = dec ? SQ_DIM - 1 : 1;
            find_letter(first, r1, c1);
            find_letter(second, r2, c2);
            if (r1 == r2) begin
                o1.letter = square_cell(r1, (c1 + step) % SQ_DIM);
                o2.letter = square_cell(r2, (c2 + step) % SQ_DIM);
            end else if (c1 == c2) begin
                o1.letter = square_cell((r1 + step) % SQ_DIM, c1);
                o2.letter = square_cell((r2 + step) % SQ_DIM, c2);
            end else begin
                o1.letter = square_cell(r1, c2);
                o2.letter = square_cell(r2, c1);
            end
            o1.last = 1'b0;
            o2.last = fin;
            due_letters.push_back(o1);
            due_letters.push_back(o2);
            if (dec) dec_pairs++;
            else enc_pairs++;
        endfunction

        // Called for every accepted input item.
        function void note_letter(bit dec, t_letter l, bit fin);
            t_letter l_in;
            l_in = (l == LETTER_J) ? LETTER_I : l;
            if (held_valid) begin
                if (!held_dec && held_letter == l_in) begin
                    queue_pair(held_letter, LETTER_X, 1'b0, 1'b0);
                    splits++;
                    held_letter = l_in;
                    held_dec    = dec;
                end else begin
                    queue_pair(held_letter, l_in, held_dec, fin);
                    held_valid  = 1'b0;
                    held_letter = '0;
                    held_dec    = 1'b0;
                    return;
                end
            end else begin
                held_letter = l_in;
                held_dec    = dec;
                held_valid  = 1'b1;
            end
            if (fin) begin
                queue_pair(held_letter, LETTER_X, held_dec, 1'b1);
                held_valid  = 1'b0;
                held_letter = '0;
                held_dec    = 1'b0;
            end
        endfunction

        // Called for every accepted output item.
        function void check_letter(t_letter l, bit fin);
            t_out want;
            letters_out++;
            if (due_letters.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: letter %0d last %0b arrived with nothing due",
                             $realtime, l, fin);
                return;
            end
            want = due_letters.pop_front();
            if (l !== want.letter || fin !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected letter %0d last %0b, got letter %0d last %0b",
                             $realtime, want.letter, want.last, l, fin);
            end
        endfunction
    endclass

endpackage

### tb/sv/tb_playfair_digraph_cipher.sv
// Testbench for playfair_digraph_cipher: directed and random letter streams
// checked against a scoreboard under several key squares and idling patterns.
// Depends on pf_pkg and pf_sb_pkg.
module tb_playfair_digraph_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import pf_pkg::*;
    import pf_sb_pkg::*;

    // Spare cycles waited after the last due letter has left; plenty to be sure
    // a letter parked in the pair former is not in flight.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 90;
    localparam int LIMIT_CYCLES  = 200000;

    logic     i_clk      = 1'b0;
    logic     i_rst_n    = 1'b0;
    logic     i_cfg_we   = 1'b0;
    t_cfg_idx i_cfg_idx  = '0;
    t_row     i_cfg_data = '0;
    logic     i_valid    = 1'b0;
    logic     i_func     = 1'b0;
    t_letter  i_letter_in = '0;
    logic     i_last_in  = 1'b0;
    logic     i_ready    = 1'b0;
    logic     o_ready;
    logic     o_valid;
    t_letter  o_letter_out;
    logic     o_last_out;

    digraph_scoreboard sb = new();

    // Idling percentages, changed by the main sequence between phases.
    int send_idle_pct = 18;
    int recv_idle_pct = 63;
    // Set by the main sequence to ask the receiver for one long hold-off.
    bit hold_request  = 1'b0;
    int letters_in    = 0;
    int cycle_count   = 0;

    playfair_digraph_cipher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_letter_in  (i_letter_in),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_letter_out (o_letter_out),
        .o_last_out   (o_last_out)
    );

    always #6 i_clk = ~i_clk;

    // Letter code from a lower-case character, purely for readability.
    function automatic t_letter ltr(byte ch);
        return t_letter'(ch - "a");
    endfunction

    // A key square holding the 25 usual letters (j left out) in random order.
    function automatic t_square shuffled_square();
        int      codes[25];
        int      n, k, tmp;
        t_square sq;
        n = 0;
        for (int c = 0; c < 26; c++) begin
            if (c != int'(LETTER_J)) begin
                codes[n] = c;
                n++;
            end
        end
        for (int i = 24; i > 0; i--) begin
            k        = $urandom_range(i);
            tmp      = codes[i];
            codes[i] = codes[k];
            codes[k] = tmp;
        end
        for (int i = 0; i < 25; i++) begin
            sq[i / SQ_DIM][5*(i % SQ_DIM) +: 5] = t_letter'(codes[i]);
        end
        return sq;
    endfunction

    // Offer one item and return at the edge where it is accepted. The valid
    // line is only ever given one new value per clock edge: if the sender
    // decides to pause it lowers valid once and waits, otherwise the next
    // item follows straight on with valid left high.
    task automatic send_letter(input bit f, input t_letter l, input bit fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= f;
        i_letter_in <= l;
        i_last_in   <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_letter(f, l, fin);
        letters_in++;
    endtask

    // Write every key-square row, one per cycle, and mirror it in the
    // scoreboard. Only called while the block is idle.
    task automatic write_square(input t_square sq);
        for (int r = 0; r <= int'(CFG_ROW_LAST); r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(r);
            i_cfg_data <= sq[r];
            sb.set_row(r, sq[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Stop offering, wait for every due letter and then a few cycles more.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random messages: each keeps one mode for most of its letters, repeats
    // letters now and then so that doubled-letter splits happen often, and
    // closes with a last mark. A few stray codes above z and stray mode
    // flips mixed in act as noise. The final item of the batch always carries
    // the last mark, so no letter is left pending between phases.
    task automatic send_messages(input int n_items);
        int      sent, len;
        bit      dec, f, fin;
        t_letter l, prev;
        sent = 0;
        prev = '0;
        while (sent < n_items) begin
            len = $urandom_range(1, 10);
            dec = 1'($urandom_range(1));
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (k > 0 && $urandom_range(99) < 15)
                    l = prev;
                else if ($urandom_range(99) < 3)
                    l = t_letter'($urandom_range(31, 26));
                else
                    l = t_letter'($urandom_range(25));
                f   = ($urandom_range(99) < 8) ? !dec : dec;
                fin = (k == len - 1) || (sent == n_items - 1);
                send_letter(f, l, fin);
                prev = l;
                sent++;
            end
        end
    endtask

    // Output side: check what the block hands over, then pick the next value
    // of ready. A hold-off request turns into a long stretch of ready low,
    // counted here, while the sender carries on offering items.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_ready && o_valid) sb.check_letter(o_letter_out, o_last_out);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                i_ready      <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: a run that is still going after this many cycles has hung.
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : main_sequence
        t_square sq;
        int      fails;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed letters against the square that reset leaves behind.
        // Encryption: same row, same column, rectangle, and wrap at the edges.
        send_letter(1'b0, ltr("a"), 1'b0);
        send_letter(1'b0, ltr("b"), 1'b0);
        send_letter(1'b0, ltr("a"), 1'b0);
        send_letter(1'b0, ltr("f"), 1'b0);
        send_letter(1'b0, ltr("a"), 1'b0);
        send_letter(1'b0, ltr("g"), 1'b0);
        send_letter(1'b0, ltr("e"), 1'b0);
        send_letter(1'b0, ltr("z"), 1'b0);
        // A doubled letter is split with x and the second one waits.
        send_letter(1'b0, ltr("l"), 1'b0);
        send_letter(1'b0, ltr("l"), 1'b0);
        send_letter(1'b0, ltr("m"), 1'b0);
        // A doubled letter that is also the last one gives four letters.
        send_letter(1'b0, ltr("p"), 1'b0);
        send_letter(1'b0, ltr("p"), 1'b1);
        // A lone final letter in decryption is padded with x.
        send_letter(1'b1, ltr("q"), 1'b1);
        // Decryption shifts left and up, and does not split a doubled letter.
        send_letter(1'b1, ltr("b"), 1'b0);
        send_letter(1'b1, ltr("c"), 1'b0);
        send_letter(1'b1, ltr("d"), 1'b0);
        send_letter(1'b1, ltr("d"), 1'b1);
        // j reads as i; the mode of the first letter governs the pair.
        send_letter(1'b0, ltr("j"), 1'b0);
        send_letter(1'b1, ltr("k"), 1'b0);
        // x after x keeps splitting, then the last x is padded.
        send_letter(1'b0, ltr("x"), 1'b0);
        send_letter(1'b0, ltr("x"), 1'b0);
        send_letter(1'b0, ltr("x"), 1'b1);
        // Codes past z are not in the square and sit in the top-left cell.
        send_letter(1'b1, t_letter'(26), 1'b0);
        send_letter(1'b0, t_letter'(31), 1'b0);
        send_letter(1'b0, ltr("y"), 1'b1);
        settle();

        // A shuffled square, still with a slow receiver.
        write_square(shuffled_square());
        send_messages(70);
        settle();

        // Extremes of the key-square registers with a slow sender: all
        // zeros, so every cell is a; all ones, so no letter is found and
        // every output is code 31; then random cells full of repeats and
        // codes past z.
        send_idle_pct = 63;
        recv_idle_pct = 18;
        write_square('0);
        send_messages(15);
        settle();
        write_square('1);
        send_messages(15);
        settle();
        for (int r = 0; r < SQ_DIM; r++) sq[r] = t_row'($urandom);
        write_square(sq);
        send_messages(30);
        settle();

        write_square(shuffled_square());
        send_messages(70);
        settle();

        // Back to the reset square with no idling, and one long hold-off on
        // the output so the queue fills and input ready has to drop.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_square(SQUARE_RST);
        hold_request = 1'b1;
        send_messages(60);
        settle();

        $display("Covered %0d letters in and %0d out: %0d encrypted and %0d decrypted pairs,",
                 letters_in, sb.letters_out, sb.enc_pairs, sb.dec_pairs);
        $display("%0d doubled-letter splits, six key squares and three idling patterns.",
                 sb.splits);
        fails = sb.mismatches + sb.outstanding();
        if (sb.outstanding() != 0)
            $display("%0d expected letters never arrived", sb.outstanding());
        if (fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
rtl/pf_pkg.sv
rtl/pf_pair_former.sv
rtl/pf_pair_xform.sv
rtl/pf_out_fifo.sv
rtl/playfair_digraph_cipher.sv
tb/sv/pf_sb_pkg.sv
tb/sv/tb_playfair_digraph_cipher.sv
